// File: rtl/knk_pkg.sv
`default_nettype none

package knk_pkg;

  // Number of sequence port registers, fixed by the register map.
  localparam int unsigned SEQ_REGS = 6;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned PROG_W   = 3;
  localparam int unsigned AGE_W    = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_PROGRESS    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_PAYLOAD = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_WRONG_PORT  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_GRANTED     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL  = 3'd4;

  // Input opcodes.
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KNOCK_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_PORT_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_PORT_5  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT  = 3'd7;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [PROG_W-1:0] progress;
    logic [AGE_W-1:0]  age;
  } entry_t;

  typedef struct packed {
    logic [PROG_W-1:0]                knock_count;
    logic [SEQ_REGS-1:0][PORT_W-1:0]  seq_port;
    logic [AGE_W-1:0]                 idle_limit;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PROG_W-1:0]   prog;
    logic [PROG_W-1:0]   new_prog;
    logic                refresh_age;
  } judge_res_t;

endpackage

`default_nettype wire

// File: rtl/knk_if.sv
`default_nettype none

interface knk_in_if;
  import knk_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] source_address;
  logic [PORT_W-1:0] dest_port;
  logic              is_tcp;
  logic              syn_flag;
  logic              ack_flag;
  logic              length_ok;
  logic              payload_valid;

  modport source (output valid, opcode, source_address, dest_port, is_tcp, syn_flag,
                  ack_flag, length_ok, payload_valid, input ready);
  modport sink (input valid, opcode, source_address, dest_port, is_tcp, syn_flag,
                ack_flag, length_ok, payload_valid, output ready);
endinterface

interface knk_out_if;
  import knk_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   knocker_address;
  logic [PROG_W-1:0]   progress;

  modport source (output valid, status, knocker_address, progress, input ready);
  modport sink (input valid, status, knocker_address, progress, output ready);
endinterface

`default_nettype wire

// File: rtl/knk_cfg_regs.sv
`default_nettype none

module knk_cfg_regs import knk_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t                 cfg_r;
  logic [CFG_IDX_W-1:0] seq_sel;

  assign seq_sel = cfg_index - REG_SEQ_PORT_0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.knock_count <= PROG_W'(1);
      cfg_r.seq_port    <= '0;
      cfg_r.idle_limit  <= AGE_W'(10);
    end else if (cfg_we) begin
      if (cfg_index == REG_KNOCK_COUNT) begin
        cfg_r.knock_count <= cfg_wdata[PROG_W-1:0];
      end else if (cfg_index == REG_IDLE_LIMIT) begin
        cfg_r.idle_limit <= cfg_wdata[AGE_W-1:0];
      end else if (cfg_index inside {[REG_SEQ_PORT_0:REG_SEQ_PORT_5]}) begin
        cfg_r.seq_port[seq_sel] <= cfg_wdata[PORT_W-1:0];
      end
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/knk_table_ram.sv
`default_nettype none

module knk_table_ram import knk_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/knk_judge.sv
`default_nettype none

module knk_judge import knk_pkg::*; #(
  parameter int unsigned MAX_KNOCKS = 6
) (
  input  wire cfg_t               cfg,
  input  wire logic               found,
  input  wire logic [PROG_W-1:0]  cur,
  input  wire logic [PORT_W-1:0]  dest_port,
  input  wire logic               length_ok,
  input  wire logic               payload_valid,
  output judge_res_t              res
);

  localparam logic [PROG_W-1:0] MAX_K = PROG_W'(MAX_KNOCKS);

  logic [PORT_W-1:0] want_port;
  logic              port_hit;
  logic [PROG_W-1:0] next_prog;

  // Select the sequence port that the current progress expects next.
  always_comb begin
    want_port = '0;
    for (int i = 0; i < SEQ_REGS; i++) begin
      if (cur == PROG_W'(i)) begin
        want_port = cfg.seq_port[i];
      end
    end
  end

  assign port_hit  = (cur < MAX_K) && (want_port == dest_port);
  assign next_prog = cur + PROG_W'(1);

  always_comb begin
    res = '0;
    if (!found) begin
      res.status = STATUS_TABLE_FULL;
    end else if (!length_ok) begin
      res.status = STATUS_BAD_PAYLOAD;
    end else if (!port_hit) begin
      res.status      = STATUS_WRONG_PORT;
      res.refresh_age = 1'b1;
    end else if (!payload_valid) begin
      res.status = STATUS_BAD_PAYLOAD;
    end else begin
      res.prog        = next_prog;
      res.refresh_age = 1'b1;
      if (next_prog >= cfg.knock_count) begin
        res.status = STATUS_GRANTED;
      end else begin
        res.status   = STATUS_PROGRESS;
        res.new_prog = next_prog;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/port_knock_sequence_tracker_unit.sv
`default_nettype none

// Port knock tracker. Each accepted packet transaction that is a TCP SYN without ACK looks up
// its source address in a table of TABLE_ENTRIES slots, inserting it in the lowest free slot
// when absent, judges the knock against the configured port sequence and returns one result
// transaction; other packets are dropped silently. A tick transaction ages every used entry and
// frees those idle longer than idle_limit; it returns no result. The table lives in a
// synchronous memory with one read and one write port, and the scan reads one entry per cycle,
// so a tick reads the whole table and a tracked packet reads until its address is found or the
// last entry is read; a dropped packet never leaves the idle state. One transaction is in work
// at a time, while a finished result may still wait in the output register. Configuration must
// be written by the user through the cfg port while idle; the block does not enforce it.
module port_knock_sequence_tracker_unit import knk_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned MAX_KNOCKS    = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  knk_in_if.sink                     in_chan,
  knk_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned      IDX_W    = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  cfg_t       cfg;
  judge_res_t jres;
  entry_t     rd_data;
  entry_t     wr_data;

  logic [1:0]               state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0] used_r;
  logic                     issue_r, rd_vld_r, hit_r, free_r;
  logic [IDX_W-1:0]         rd_idx_r, ret_idx_r, hit_idx_r, free_idx_r;
  logic [PROG_W-1:0]        hit_prog_r;
  logic [AGE_W-1:0]         hit_age_r;

  // Captured transaction.
  logic              tick_r, len_ok_r, pay_ok_r;
  logic [ADDR_W-1:0] key_r;
  logic [PORT_W-1:0] port_r;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [PROG_W-1:0]   out_prog_r;

  logic              in_fire, knock_pkt, start;
  logic              ret_used, ret_match, ret_last, scan_done, rd_en;
  logic              tick_wr, apply_fire, found, apply_wr, wr_en;
  logic [IDX_W-1:0]  slot, wr_addr;
  logic [PROG_W-1:0] cur;
  logic [AGE_W-1:0]  cur_age, aged;

  knk_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid & in_chan.ready;
  assign knock_pkt     = in_chan.is_tcp & in_chan.syn_flag & ~in_chan.ack_flag;
  assign start         = in_fire & ((in_chan.opcode == OP_TICK) | knock_pkt);

  // Scan pipeline: a read issued in one cycle returns its entry in the next. The lookup stops
  // at the first used entry whose address matches; the first free slot is noted along the way.
  assign ret_used  = used_r[ret_idx_r];
  assign ret_match = rd_vld_r & ~tick_r & ret_used & (rd_data.address == key_r);
  assign ret_last  = (ret_idx_r == LAST_IDX);
  assign scan_done = rd_vld_r & (ret_match | ret_last);
  assign rd_en     = (state_r == S_SCAN) & issue_r & ~scan_done;

  // Ageing writes back the entry just read while the next one is being read, so a write and
  // a read never meet at the same entry. The packet update writes only after the scan has
  // ended, and the next scan starts no earlier than the cycle after that write.
  assign tick_wr = rd_vld_r & tick_r & ret_used;
  assign aged    = (rd_data.age == '1) ? rd_data.age : rd_data.age + AGE_W'(1);

  assign apply_fire = (state_r == S_APPLY) & (~out_valid_r | out_chan.ready);
  assign found      = hit_r | free_r;
  assign slot       = hit_r ? hit_idx_r : free_idx_r;
  assign cur        = hit_r ? hit_prog_r : '0;
  assign cur_age    = hit_r ? hit_age_r : '0;
  assign apply_wr   = apply_fire & found;

  knk_judge #(
    .MAX_KNOCKS (MAX_KNOCKS)
  ) u_judge (
    .cfg           (cfg),
    .found         (found),
    .cur           (cur),
    .dest_port     (port_r),
    .length_ok     (len_ok_r),
    .payload_valid (pay_ok_r),
    .res           (jres)
  );

  assign wr_en   = tick_wr | apply_wr;
  assign wr_addr = tick_wr ? ret_idx_r : slot;

  always_comb begin
    if (tick_wr) begin
      wr_data.address  = rd_data.address;
      wr_data.progress = rd_data.progress;
      wr_data.age      = aged;
    end else begin
      wr_data.address  = key_r;
      wr_data.progress = jres.new_prog;
      wr_data.age      = jres.refresh_age ? '0 : cur_age;
    end
  end

  knk_table_ram #(
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_idx_r),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = tick_r ? S_IDLE : S_APPLY;
        end
      end
      S_APPLY: begin
        if (apply_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = apply_fire | (out_valid_r & ~out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      issue_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      rd_idx_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_en;
      if (start) begin
        issue_r  <= 1'b1;
        hit_r    <= 1'b0;
        free_r   <= 1'b0;
        rd_idx_r <= '0;
      end else if (rd_en) begin
        if (rd_idx_r == LAST_IDX) begin
          issue_r <= 1'b0;
        end else begin
          rd_idx_r <= rd_idx_r + IDX_W'(1);
        end
      end
      if (ret_match) begin
        hit_r <= 1'b1;
      end
      if (rd_vld_r & ~tick_r & ~ret_used & ~free_r) begin
        free_r <= 1'b1;
      end
      if (tick_wr && (aged > cfg.idle_limit)) begin
        used_r[ret_idx_r] <= 1'b0;
      end
      if (apply_wr) begin
        used_r[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ret_idx_r <= rd_idx_r;
    if (start) begin
      tick_r   <= (in_chan.opcode == OP_TICK);
      key_r    <= in_chan.source_address;
      port_r   <= in_chan.dest_port;
      len_ok_r <= in_chan.length_ok;
      pay_ok_r <= in_chan.payload_valid;
    end
    if (ret_match) begin
      hit_idx_r  <= ret_idx_r;
      hit_prog_r <= rd_data.progress;
      hit_age_r  <= rd_data.age;
    end
    if (rd_vld_r & ~tick_r & ~ret_used & ~free_r) begin
      free_idx_r <= ret_idx_r;
    end
    if (apply_fire) begin
      out_status_r <= jres.status;
      out_addr_r   <= key_r;
      out_prog_r   <= jres.prog;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = out_status_r;
  assign out_chan.knocker_address = out_addr_r;
  assign out_chan.progress        = out_prog_r;

endmodule

`default_nettype wire

// File: rtl/knk_checker.sv
`default_nettype none

module knk_checker import knk_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                in_opcode,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [ADDR_W-1:0]   out_knocker_address,
  input wire logic [PROG_W-1:0]   out_progress
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_knocker_address) && $stable(out_progress))
    else $error("result changed while stalled");

  // A tick occupies the block for a full table scan, so the input is not ready right after it.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_TICK) |=> !in_ready)
    else $error("input taken again right after a tick");

  // Resets and a full table report no progress.
  a_reset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_TABLE_FULL || out_status == STATUS_BAD_PAYLOAD ||
    out_status == STATUS_WRONG_PORT) |-> out_progress == '0)
    else $error("nonzero progress on a reset or full result");

  // A matched knock always reports at least one knock.
  a_match_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_GRANTED || out_status == STATUS_PROGRESS) |->
    out_progress != '0)
    else $error("zero progress on a matched knock");

endmodule

bind port_knock_sequence_tracker_unit knk_checker u_knk_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_chan.valid),
  .in_ready            (in_chan.ready),
  .in_opcode           (in_chan.opcode),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_status          (out_chan.status),
  .out_knocker_address (out_chan.knocker_address),
  .out_progress        (out_chan.progress)
);

`default_nettype wire
